// File: hdl/ctw_pkg.sv
// ----------------------------------------------------------------------------
// ctw_pkg: shared constants for the text console writer
// Screen geometry, cell codes and the derived widths used by the engine.
// ----------------------------------------------------------------------------
package ctw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // fixed widths of the request and result fields
  localparam int IDX_W      = 11;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = CHAR_W + COLOR_W;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;

  // internal widths
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_IW     = $clog2(COLUMNS);
  localparam int ROW_IW     = $clog2(ROWS);
  localparam int SUM_W      = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

endpackage

// File: hdl/ctw_ram.sv
// ----------------------------------------------------------------------------
// ctw_ram: generic single-port RAM
// One access per cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
module ctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Keeps the character grid in one RAM, rotated by whole rows, and the cursor
// in registers. Writes place a character or take a newline; reads return a cell.
// ----------------------------------------------------------------------------
//  channel   ports                                          handshake
//  request   in_func in_char_code in_text_color in_cell_index  start & !busy
//  result    out_cell_data out_cursor_column out_cursor_line
//            out_did_scroll                                  out_valid, 1 cycle
//
// A write request's result shows in the cycle after it is accepted.
// A read request goes through the registered RAM read, then the result registers.
// A write that scrolls rotates the row base and blanks the new bottom row:
// busy stays high while that row is cleared, one cell a cycle.
// After reset the RAM is cleared one cell a cycle, with busy high until it
// is done. The receiver cannot stall; results never wait.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [ctw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [ctw_pkg::COLOR_W-1:0] in_text_color,
  input  logic [ctw_pkg::IDX_W-1:0]   in_cell_index,
  output logic                        out_valid,
  output logic [ctw_pkg::CELL_W-1:0]  out_cell_data,
  output logic [ctw_pkg::OUT_COL_W-1:0] out_cursor_column,
  output logic [ctw_pkg::OUT_ROW_W-1:0] out_cursor_line,
  output logic                        out_did_scroll
);

  import ctw_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ROWCLR
  } state_t;

  state_t              state_r;
  logic [COL_IW-1:0]   col_r;
  logic [ROW_IW-1:0]   row_r;
  logic [ADDR_W-1:0]   top_base_r;   // physical start of logical row 0
  logic [ADDR_W-1:0]   line_base_r;  // physical start of the cursor row
  logic [ADDR_W-1:0]   clr_addr_r;
  logic [ADDR_W-1:0]   clr_left_r;
  logic                rd_in_range_r;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [CELL_W-1:0]   out_cell_data_r;
  logic                out_did_scroll_r;

  logic                accept;
  logic                is_newline;
  logic                adv_row;
  logic                do_scroll;
  logic                col_last;
  logic                row_last;
  logic [COL_IW-1:0]   col_nxt;
  logic [ROW_IW-1:0]   row_nxt;
  logic [ADDR_W:0]     line_sum;
  logic [ADDR_W:0]     top_sum;
  logic [ADDR_W-1:0]   line_base_nxt;
  logic [ADDR_W-1:0]   top_base_nxt;
  logic [ADDR_W-1:0]   wr_addr;
  logic [SUM_W-1:0]    rd_sum;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_in_range;

  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_addr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [CELL_W-1:0]   ram_rdata;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // a write answers the cycle after accept, a read once the RAM data is back
  assign out_valid_nxt = (state_r == ST_READ) || (accept && (in_func == FUNC_WRITE));

  // cursor advance for a write request
  assign is_newline = (in_char_code == NEWLINE_CODE);
  assign col_last   = (col_r == COL_IW'(COLUMNS - 1));
  assign row_last   = (row_r == ROW_IW'(ROWS - 1));
  assign adv_row    = is_newline || col_last;
  assign do_scroll  = adv_row && row_last;
  assign col_nxt    = adv_row ? '0 : col_r + 1'b1;
  assign row_nxt    = (adv_row && !row_last) ? row_r + 1'b1 : row_r;

  // row bases move one row down the ring, wrapping at the end of the RAM
  assign line_sum = {1'b0, line_base_r} + (ADDR_W+1)'(COLUMNS);
  assign top_sum  = {1'b0, top_base_r} + (ADDR_W+1)'(COLUMNS);

  always_comb begin
    line_base_nxt = line_base_r;
    if (adv_row) begin
      if (line_sum >= (ADDR_W+1)'(CELL_COUNT)) begin
        line_base_nxt = ADDR_W'(line_sum - (ADDR_W+1)'(CELL_COUNT));
      end else begin
        line_base_nxt = ADDR_W'(line_sum);
      end
    end
  end

  always_comb begin
    top_base_nxt = top_base_r;
    if (do_scroll) begin
      if (top_sum >= (ADDR_W+1)'(CELL_COUNT)) begin
        top_base_nxt = ADDR_W'(top_sum - (ADDR_W+1)'(CELL_COUNT));
      end else begin
        top_base_nxt = ADDR_W'(top_sum);
      end
    end
  end

  assign wr_addr = line_base_r + ADDR_W'(col_r);

  // logical cell index to physical address through the row ring
  assign rd_in_range = (SUM_W'(in_cell_index) < SUM_W'(CELL_COUNT));
  assign rd_sum      = SUM_W'(in_cell_index) + SUM_W'(top_base_r);

  always_comb begin
    if (rd_sum >= SUM_W'(CELL_COUNT)) begin
      rd_addr = ADDR_W'(rd_sum - SUM_W'(CELL_COUNT));
    end else begin
      rd_addr = ADDR_W'(rd_sum);
    end
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = clr_addr_r;
    ram_wdata = BLANK_CELL;
    unique case (state_r)
      ST_CLEAR, ST_ROWCLR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_READ) begin
            ram_re   = rd_in_range;
            ram_addr = rd_addr;
          end else begin
            ram_we    = !is_newline;
            ram_addr  = wr_addr;
            ram_wdata = {in_text_color, in_char_code};
          end
        end
      end
      ST_READ: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ctw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      col_r            <= '0;
      row_r            <= '0;
      top_base_r       <= '0;
      line_base_r      <= '0;
      clr_addr_r       <= '0;
      clr_left_r       <= ADDR_W'(CELL_COUNT - 1);
      rd_in_range_r    <= 1'b0;
      out_valid_r      <= 1'b0;
      out_did_scroll_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_CLEAR, ST_ROWCLR: begin
          if (clr_left_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
            clr_left_r <= clr_left_r - 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_func == FUNC_READ) begin
              rd_in_range_r <= rd_in_range;
              state_r       <= ST_READ;
            end else begin
              col_r            <= col_nxt;
              row_r            <= row_nxt;
              line_base_r      <= line_base_nxt;
              top_base_r       <= top_base_nxt;
              out_cell_data_r  <= '0;
              out_did_scroll_r <= do_scroll;
              if (do_scroll) begin
                // blank the old top row, which becomes the new bottom row
                clr_addr_r <= top_base_r;
                clr_left_r <= ADDR_W'(COLUMNS - 1);
                state_r    <= ST_ROWCLR;
              end
            end
          end
        end
        ST_READ: begin
          out_cell_data_r  <= rd_in_range_r ? ram_rdata : '0;
          out_did_scroll_r <= 1'b0;
          state_r          <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_data     = out_cell_data_r;
  assign out_cursor_column = OUT_COL_W'(col_r);
  assign out_cursor_line   = OUT_ROW_W'(row_r);
  assign out_did_scroll    = out_did_scroll_r;

endmodule

// File: tb/text_console_writer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_test: self-checking bench for the text console writer
// Sends write and read requests through the start/busy port and keeps its own
// screen and cursor copy to predict each result. Every out_valid result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module text_console_writer_test;
  import ctw_pkg::*;

  localparam int STALL_LIMIT = 10000;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic [OUT_COL_W-1:0] column;
    logic [OUT_ROW_W-1:0] line;
    logic                 scrolled;
  } console_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_func;
  logic [CHAR_W-1:0]    in_char_code;
  logic [COLOR_W-1:0]   in_text_color;
  logic [IDX_W-1:0]     in_cell_index;
  logic                 out_valid;
  logic [CELL_W-1:0]    out_cell_data;
  logic [OUT_COL_W-1:0] out_cursor_column;
  logic [OUT_ROW_W-1:0] out_cursor_line;
  logic                 out_did_scroll;

  // screen and cursor as the block should hold them
  logic [CELL_W-1:0] screen_copy [CELL_COUNT];
  int                cursor_col;
  int                cursor_row;

  console_result_t   expected_status_q [$];
  int                err_count = 0;
  int                stall_cycles = 0;
  int                n_writes;
  int                n_newlines;
  int                n_reads;
  int                n_scrolls;
  int                newline_weight;
  bit                allow_gaps;

  text_console_writer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_char_code      (in_char_code),
    .in_text_color     (in_text_color),
    .in_cell_index     (in_cell_index),
    .out_valid         (out_valid),
    .out_cell_data     (out_cell_data),
    .out_cursor_column (out_cursor_column),
    .out_cursor_line   (out_cursor_line),
    .out_did_scroll    (out_did_scroll)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic console_result_t apply_console_request(
    input func_t f, input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] color,
    input logic [IDX_W-1:0] idx);
    console_result_t r;
    int pos;
    int i;
    r = '0;
    if (f == FUNC_READ) begin
      if (idx < CELL_COUNT) r.cell_data = screen_copy[idx];
    end else begin
      if (ch == NEWLINE_CODE) begin
        cursor_row++;
        cursor_col = 0;
      end else begin
        pos = cursor_row * COLUMNS + cursor_col;
        if (pos < CELL_COUNT) screen_copy[pos] = {color, ch};
        cursor_col++;
        if (cursor_col >= COLUMNS) begin
          cursor_col = 0;
          cursor_row++;
        end
      end
      if (cursor_row >= ROWS) begin
        // shift every row up and blank the bottom one
        for (i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_copy[i] = screen_copy[i + COLUMNS];
        for (i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) screen_copy[i] = BLANK_CELL;
        cursor_row = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.column = cursor_col[OUT_COL_W-1:0];
    r.line   = cursor_row[OUT_ROW_W-1:0];
    return r;
  endfunction

  // Drive one request and hold it until the block takes it. Start stays high
  // so that a following request can go out on the next edge.
  task automatic send_request(input func_t f, input logic [CHAR_W-1:0] ch,
                              input logic [COLOR_W-1:0] color, input logic [IDX_W-1:0] idx);
    console_result_t r;
    start         <= 1'b1;
    in_func       <= f;
    in_char_code  <= ch;
    in_text_color <= color;
    in_cell_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_console_request(f, ch, color, idx);
    expected_status_q.push_back(r);
    if (f == FUNC_READ) n_reads++;
    else if (ch == NEWLINE_CODE) n_newlines++;
    else n_writes++;
    if (r.scrolled) n_scrolls++;
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    int roll;
    int pos;
    logic [IDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    idx  = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    if (roll < newline_weight) begin
      send_request(FUNC_WRITE, NEWLINE_CODE, COLOR_W'($urandom), idx);
    end else if (roll < 62) begin
      send_request(FUNC_WRITE, CHAR_W'($urandom), COLOR_W'($urandom), idx);
    end else if (roll < 78) begin
      // read back the cell left of the cursor: the one just written, unless a newline came last
      pos = cursor_row * COLUMNS + cursor_col - 1;
      if (pos < 0) pos = 0;
      send_request(FUNC_READ, CHAR_W'($urandom), COLOR_W'($urandom), IDX_W'(pos));
    end else if (roll < 94) begin
      send_request(FUNC_READ, CHAR_W'($urandom), COLOR_W'($urandom),
                   IDX_W'($urandom_range(0, CELL_COUNT - 1)));
    end else begin
      send_request(FUNC_READ, CHAR_W'($urandom), COLOR_W'($urandom),
                   IDX_W'($urandom_range(CELL_COUNT, (1 << IDX_W) - 1)));
    end
    if (allow_gaps && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 5));
  endtask

  task automatic test_blank_after_reset();
    send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(0));
    send_request(FUNC_READ, 8'hFF, 8'hFF, IDX_W'(CELL_COUNT - 1));
    send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(CELL_COUNT));
    send_request(FUNC_READ, 8'hFF, 8'hFF, {IDX_W{1'b1}});
    send_request(FUNC_READ, 8'h5A, 8'hA5, IDX_W'(COLUMNS));
  endtask

  task automatic test_character_extremes();
    send_request(FUNC_WRITE, 8'h00, 8'h00, {IDX_W{1'b1}});
    send_request(FUNC_WRITE, 8'hFF, 8'hFF, IDX_W'(0));
    send_request(FUNC_WRITE, 8'h0B, 8'h80, IDX_W'(0));
    send_request(FUNC_WRITE, 8'h09, 8'h01, IDX_W'(0));
    send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(0));
    send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(1));
    send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(2));
    send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(3));
  endtask

  task automatic test_newline();
    // newline stores nothing: the cell under the cursor stays as it was
    send_request(FUNC_WRITE, NEWLINE_CODE, 8'hFF, IDX_W'(0));
    send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(4));
    send_request(FUNC_WRITE, NEWLINE_CODE, 8'h00, IDX_W'(0));
    send_request(FUNC_WRITE, 8'h41, 8'h1E, IDX_W'(0));
    send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(2 * COLUMNS));
    send_request(FUNC_READ, 8'h00, 8'h00, IDX_W'(COLUMNS));
  endtask

  task automatic test_random_traffic(input int count);
    int k;
    allow_gaps = 1'b1;
    for (k = 0; k < count; k++) begin
      // vary line length: long stretches without newline force wraps
      if (k % 100 == 0) newline_weight = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 15);
      send_random_request();
    end
  endtask

  task automatic test_drain_pauses(input int count);
    int k;
    allow_gaps = 1'b1;
    newline_weight = 10;
    for (k = 0; k < count; k++) begin
      send_random_request();
      if (k % 25 == 24) wait_for_drain();
    end
  endtask

  task automatic test_full_rate(input int count);
    int k;
    allow_gaps = 1'b0;
    for (k = 0; k < count; k++) begin
      if (k % 100 == 0) newline_weight = $urandom_range(0, 12);
      send_random_request();
    end
  endtask

  function automatic void report_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    console_result_t want;
    if (rst_n && out_valid) begin
      if (expected_status_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual cell 0x%0h",
                 $time, out_cell_data);
        err_count++;
      end else begin
        want = expected_status_q.pop_front();
        report_field("cell_data", want.cell_data, out_cell_data);
        report_field("cursor_column", want.column, out_cursor_column);
        report_field("cursor_line", want.line, out_cursor_line);
        report_field("did_scroll", want.scrolled, out_did_scroll);
      end
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("[text_console_writer] ERROR");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_func       <= 1'b0;
    in_char_code  <= '0;
    in_text_color <= '0;
    in_cell_index <= '0;
    n_writes       = 0;
    n_newlines     = 0;
    n_reads        = 0;
    n_scrolls      = 0;
    newline_weight = 8;
    allow_gaps     = 1'b0;
    for (i = 0; i < CELL_COUNT; i++) screen_copy[i] = BLANK_CELL;
    cursor_col = 0;
    cursor_row = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_blank_after_reset();
    test_character_extremes();
    test_newline();
    test_random_traffic(850);
    test_drain_pauses(150);
    test_full_rate(400);

    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d character writes, %0d newlines, %0d reads, %0d scrolls",
             n_writes, n_newlines, n_reads, n_scrolls);
    $display("with idle bursts, drain pauses and a back-to-back stretch; %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("[text_console_writer] OK");
    end else begin
      $display("[text_console_writer] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ctw_pkg.sv
hdl/ctw_ram.sv
hdl/text_console_writer.sv
tb/text_console_writer_test.sv
